>>> src/vfv_pkg.sv
package vfv_pkg;

    localparam int CHUNK_XY_DEF     = 16;
    localparam int CHUNK_HEIGHT_DEF = 256;

    localparam int W_CMD  = 2;
    localparam int W_XY   = 4;
    localparam int W_Z    = 8;
    localparam int W_SIDE = 2;
    localparam int W_POS  = 4;
    localparam int W_MASK = 6;

    localparam logic [W_CMD-1:0] CMD_WR_OWN  = 2'd0;
    localparam logic [W_CMD-1:0] CMD_WR_EDGE = 2'd1;
    localparam logic [W_CMD-1:0] CMD_QUERY   = 2'd2;

    localparam logic [W_SIDE-1:0] SIDE_XN = 2'd0;
    localparam logic [W_SIDE-1:0] SIDE_XP = 2'd1;
    localparam logic [W_SIDE-1:0] SIDE_YN = 2'd2;
    localparam logic [W_SIDE-1:0] SIDE_YP = 2'd3;

endpackage

>>> src/vfv_cmd_if.sv
interface vfv_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [vfv_pkg::W_CMD-1:0]   command;
    logic [vfv_pkg::W_XY-1:0]    x;
    logic [vfv_pkg::W_XY-1:0]    y;
    logic [vfv_pkg::W_Z-1:0]     z;
    logic [vfv_pkg::W_SIDE-1:0]  side;
    logic [vfv_pkg::W_POS-1:0]   edge_pos;
    logic                        solid;

    modport source (output valid, command, x, y, z, side, edge_pos, solid, input ready);
    modport sink   (input valid, command, x, y, z, side, edge_pos, solid, output ready);
endinterface

>>> src/vfv_face_if.sv
interface vfv_face_if;
    logic                        valid;
    logic                        ready;
    logic [vfv_pkg::W_MASK-1:0]  face_mask;
    logic                        is_solid;

    modport source (output valid, face_mask, is_solid, input ready);
    modport sink   (input valid, face_mask, is_solid, output ready);
endinterface

>>> src/vfv_ram_2r1w.sv
module vfv_ram_2r1w #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wa,
    input  logic                     i_wd,
    input  logic                     i_re_a,
    input  logic [$clog2(DEPTH)-1:0] i_ra_a,
    input  logic                     i_re_b,
    input  logic [$clog2(DEPTH)-1:0] i_ra_b,
    output logic                     o_rd_a,
    output logic                     o_rd_b
);

    logic r_mem [DEPTH];
    logic r_rd_a;
    logic r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        if (i_re_a) begin
            r_rd_a <= r_mem[i_ra_a];
        end
        if (i_re_b) begin
            r_rd_b <= r_mem[i_ra_b];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

>>> src/voxel_face_visibility_unit.sv
// Channel  Dir  Fields                                       Accepted when
// i_cmd    in   command x y z side edge_pos solid            valid && ready
// o_face   out  face_mask is_solid                           valid && ready
//
// A write is stored at the edge that accepts it.
// A query gathers seven voxel bits from the two read ports of the
// own voxel memory over four reads, edge bits from the edge memory alongside.
// Reset clears control only; both voxel memories hold garbage until written.
// A finished result waits in the output register; a stalled output holds the
// next query in its last step and blocks further items until the result leaves.
module voxel_face_visibility_unit #(
    parameter int CHUNK_XY     = vfv_pkg::CHUNK_XY_DEF,
    parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vfv_cmd_if.sink    i_cmd,
    vfv_face_if.source o_face
);

    localparam int XB         = $clog2(CHUNK_XY);
    localparam int ZB         = $clog2(CHUNK_HEIGHT);
    localparam int OWN_DEPTH  = CHUNK_XY * CHUNK_XY * CHUNK_HEIGHT;
    localparam int EDGE_DEPTH = 4 * CHUNK_XY * CHUNK_HEIGHT;
    localparam int OAW        = $clog2(OWN_DEPTH);
    localparam int EAW        = $clog2(EDGE_DEPTH);

    localparam logic [XB-1:0]  X_MAX   = XB'(CHUNK_XY - 1);
    localparam logic [ZB-1:0]  Z_MAX   = ZB'(CHUNK_HEIGHT - 1);
    localparam logic [OAW-1:0] ROW_O   = OAW'(CHUNK_XY);
    localparam logic [OAW-1:0] PLANE_O = OAW'(CHUNK_XY * CHUNK_XY);
    localparam logic [EAW-1:0] ROW_E   = EAW'(CHUNK_XY);
    localparam logic [EAW-1:0] SIDE_E  = EAW'(CHUNK_XY * CHUNK_HEIGHT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_RD3,
        S_FIN
    } t_state;

    function automatic logic [OAW-1:0] own_addr(input logic [XB-1:0] ax,
                                                input logic [XB-1:0] ay,
                                                input logic [ZB-1:0] az);
        return OAW'(ax) + OAW'(ay) * ROW_O + OAW'(az) * PLANE_O;
    endfunction

    function automatic logic [EAW-1:0] edge_addr(input logic [vfv_pkg::W_SIDE-1:0] as,
                                                 input logic [XB-1:0] ap,
                                                 input logic [ZB-1:0] az);
        return EAW'(as) * SIDE_E + EAW'(az) * ROW_E + EAW'(ap);
    endfunction

    t_state r_state;
    logic   r_out_valid;
    logic [vfv_pkg::W_MASK-1:0] r_mask;
    logic   r_solid;
    logic [XB-1:0] r_x;
    logic [XB-1:0] r_y;
    logic [ZB-1:0] r_z;
    logic   r_inside;
    logic   r_center;
    logic   r_bottom;
    logic   r_left;
    logic   r_right;
    logic   r_back;
    logic   r_front;

    logic ready;
    logic accept;
    logic out_free;
    logic res_load;
    logic in_inside;
    logic edge_ok;
    logic q_accept;
    logic q_start;
    logic in_steps;

    logic [XB-1:0] cx, cy, xm, xp, ym, yp;
    logic [ZB-1:0] cz, zm, zp;

    logic           own_we, own_re_a, own_re_b, own_rd_a, own_rd_b;
    logic [OAW-1:0] own_wa, own_ra_a, own_ra_b;
    logic           edge_we, edge_re_a, edge_re_b, edge_rd_a, edge_rd_b;
    logic [EAW-1:0] edge_wa, edge_ra_a, edge_ra_b;

    logic [vfv_pkg::W_MASK-1:0] faces;
    logic [vfv_pkg::W_MASK-1:0] n_mask;
    logic                       n_solid;

    assign out_free = !r_out_valid || o_face.ready;
    assign res_load = (r_state == S_FIN) && out_free;
    assign ready    = (r_state == S_IDLE) || ((r_state == S_FIN) && out_free);
    assign accept   = i_cmd.valid && ready;
    assign i_cmd.ready = ready;

    assign in_inside = (32'(i_cmd.x) < CHUNK_XY) && (32'(i_cmd.y) < CHUNK_XY)
                    && (32'(i_cmd.z) < CHUNK_HEIGHT);
    assign edge_ok   = (32'(i_cmd.edge_pos) < CHUNK_XY) && (32'(i_cmd.z) < CHUNK_HEIGHT);
    assign q_accept  = accept && (i_cmd.command == vfv_pkg::CMD_QUERY);
    assign q_start   = q_accept && in_inside;
    assign in_steps  = (r_state == S_RD1) || (r_state == S_RD2) || (r_state == S_RD3);

    assign cx = in_steps ? r_x : XB'(i_cmd.x);
    assign cy = in_steps ? r_y : XB'(i_cmd.y);
    assign cz = in_steps ? r_z : ZB'(i_cmd.z);
    assign xm = (cx == '0)    ? cx : cx - XB'(1);
    assign xp = (cx == X_MAX) ? cx : cx + XB'(1);
    assign ym = (cy == '0)    ? cy : cy - XB'(1);
    assign yp = (cy == X_MAX) ? cy : cy + XB'(1);
    assign zm = (cz == '0)    ? cz : cz - ZB'(1);
    assign zp = (cz == Z_MAX) ? cz : cz + ZB'(1);

    assign own_we  = accept && (i_cmd.command == vfv_pkg::CMD_WR_OWN) && in_inside;
    assign own_wa  = own_addr(XB'(i_cmd.x), XB'(i_cmd.y), ZB'(i_cmd.z));
    assign edge_we = accept && (i_cmd.command == vfv_pkg::CMD_WR_EDGE) && edge_ok;
    assign edge_wa = edge_addr(i_cmd.side, XB'(i_cmd.edge_pos), ZB'(i_cmd.z));

    always_comb begin
        own_ra_a  = own_addr(cx, cy, cz);
        own_ra_b  = own_addr(cx, cy, zm);
        own_re_a  = q_start;
        own_re_b  = q_start;
        edge_ra_a = edge_addr(vfv_pkg::SIDE_XN, cy, cz);
        edge_ra_b = edge_addr(vfv_pkg::SIDE_XP, cy, cz);
        edge_re_a = 1'b0;
        edge_re_b = 1'b0;
        case (r_state)
            S_RD1: begin
                own_ra_a  = own_addr(xm, cy, cz);
                own_ra_b  = own_addr(xp, cy, cz);
                own_re_a  = r_inside;
                own_re_b  = r_inside;
                edge_re_a = r_inside;
                edge_re_b = r_inside;
            end
            S_RD2: begin
                own_ra_a  = own_addr(cx, ym, cz);
                own_ra_b  = own_addr(cx, yp, cz);
                own_re_a  = r_inside;
                own_re_b  = r_inside;
                edge_ra_a = edge_addr(vfv_pkg::SIDE_YN, cx, cz);
                edge_ra_b = edge_addr(vfv_pkg::SIDE_YP, cx, cz);
                edge_re_a = r_inside;
                edge_re_b = r_inside;
            end
            S_RD3: begin
                own_ra_a = own_addr(cx, cy, zp);
                own_re_a = r_inside;
                own_re_b = 1'b0;
            end
            default: begin
            end
        endcase
    end

    vfv_ram_2r1w #(
        .DEPTH (OWN_DEPTH)
    ) u_own_ram (
        .i_clk  (i_clk),
        .i_we   (own_we),
        .i_wa   (own_wa),
        .i_wd   (i_cmd.solid),
        .i_re_a (own_re_a),
        .i_ra_a (own_ra_a),
        .i_re_b (own_re_b),
        .i_ra_b (own_ra_b),
        .o_rd_a (own_rd_a),
        .o_rd_b (own_rd_b)
    );

    vfv_ram_2r1w #(
        .DEPTH (EDGE_DEPTH)
    ) u_edge_ram (
        .i_clk  (i_clk),
        .i_we   (edge_we),
        .i_wa   (edge_wa),
        .i_wd   (i_cmd.solid),
        .i_re_a (edge_re_a),
        .i_ra_a (edge_ra_a),
        .i_re_b (edge_re_b),
        .i_ra_b (edge_ra_b),
        .o_rd_a (edge_rd_a),
        .o_rd_b (edge_rd_b)
    );

    assign faces = {(r_z == Z_MAX) || !own_rd_a,
                    (r_z != '0) && !r_bottom,
                    !r_front,
                    !r_back,
                    !r_right,
                    !r_left};
    assign n_solid = r_inside && r_center;
    assign n_mask  = n_solid ? faces : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= res_load || (r_out_valid && !o_face.ready);
            case (r_state)
                S_IDLE: begin
                    if (q_accept) begin
                        r_x      <= XB'(i_cmd.x);
                        r_y      <= XB'(i_cmd.y);
                        r_z      <= ZB'(i_cmd.z);
                        r_inside <= in_inside;
                        r_state  <= S_RD1;
                    end
                end
                S_RD1: begin
                    r_center <= own_rd_a;
                    r_bottom <= own_rd_b;
                    r_state  <= S_RD2;
                end
                S_RD2: begin
                    r_left  <= (r_x == '0)    ? edge_rd_a : own_rd_a;
                    r_right <= (r_x == X_MAX) ? edge_rd_b : own_rd_b;
                    r_state <= S_RD3;
                end
                S_RD3: begin
                    r_back  <= (r_y == '0)    ? edge_rd_a : own_rd_a;
                    r_front <= (r_y == X_MAX) ? edge_rd_b : own_rd_b;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_mask      <= n_mask;
                        r_solid     <= n_solid;
                        if (q_accept) begin
                            r_x      <= XB'(i_cmd.x);
                            r_y      <= XB'(i_cmd.y);
                            r_z      <= ZB'(i_cmd.z);
                            r_inside <= in_inside;
                            r_state  <= S_RD1;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_face.valid     = r_out_valid;
    assign o_face.face_mask = r_mask;
    assign o_face.is_solid  = r_solid;

    a_no_accept_in_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_steps |-> !i_cmd.ready)
        else $error("item taken while a query is in flight");

    a_query_enters_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_accept |=> (r_state == S_RD1))
        else $error("accepted query did not start its reads");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FIN))
        else $error("result loaded outside the final step");

    a_air_zero_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_face.valid && !o_face.is_solid) |-> (o_face.face_mask == '0))
        else $error("air voxel reports exposed faces");

    a_own_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        own_we |-> !(own_re_a || own_re_b || edge_re_a || edge_re_b))
        else $error("voxel write overlaps a query read");

endmodule
